// ===== rtl/clm_pkg.sv =====
package clm_pkg;

  localparam int LOCK_IDX_W   = 8;
  localparam int CLIENT_IDX_W = 3;
  localparam int SEARCH_MAX   = 8;

  typedef enum logic [1:0] {
    CTRL_CLEAR  = 2'd0,
    CTRL_IDLE   = 2'd1,
    CTRL_MODIFY = 2'd2
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_WAITED   = 2'd2,
    MODE_RETRYING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RETRY  = 2'd1,
    STAT_NOENT  = 2'd2,
    STAT_BADREL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_kind_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/clm_ctrl.sv =====
module clm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clm_pkg::sts_t sts,
  output clm_pkg::cmd_t cmd
);

  clm_pkg::ctrl_state_t state_r;
  clm_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clm_pkg::CTRL_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clm_pkg::CTRL_CLEAR: begin
        if (sts.clear_last) state_nxt = clm_pkg::CTRL_IDLE;
      end
      clm_pkg::CTRL_IDLE: begin
        if (in_valid) state_nxt = clm_pkg::CTRL_MODIFY;
      end
      clm_pkg::CTRL_MODIFY: begin
        if (!sts.out_busy) state_nxt = clm_pkg::CTRL_IDLE;
      end
      default: begin
        state_nxt = clm_pkg::CTRL_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      clm_pkg::CTRL_CLEAR: begin
        cmd.clear = 1'b1;
      end
      clm_pkg::CTRL_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      clm_pkg::CTRL_MODIFY: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/clm_dp.sv =====
module clm_dp #(
  parameter int LOCK_COUNT   = 256,
  parameter int CLIENT_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  clm_pkg::cmd_t                       cmd,
  output clm_pkg::sts_t                       sts,
  input  logic                                in_func,
  input  logic [clm_pkg::LOCK_IDX_W-1:0]      in_lock_index,
  input  logic [clm_pkg::CLIENT_IDX_W-1:0]    in_client_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [1:0]                          out_message_kind,
  output logic [clm_pkg::CLIENT_IDX_W-1:0]    out_message_client,
  output logic [clm_pkg::LOCK_IDX_W-1:0]      out_message_lock
);

  localparam int LOCK_W   = $clog2(LOCK_COUNT);
  localparam int CLIENT_W = $clog2(CLIENT_COUNT);
  localparam int STATE_W  = 3 + CLIENT_COUNT;
  localparam int SEARCH_N =
    (CLIENT_COUNT < clm_pkg::SEARCH_MAX) ? CLIENT_COUNT : clm_pkg::SEARCH_MAX;

  logic [STATE_W-1:0]  mem_state [LOCK_COUNT];
  logic [CLIENT_W-1:0] mem_holder [LOCK_COUNT];

  logic [LOCK_W-1:0]   clr_cnt_r;
  logic [LOCK_W-1:0]   clr_cnt_nxt;

  logic                              req_func_r;
  logic                              req_ok_r;
  logic [LOCK_W-1:0]                 req_addr_r;
  logic [clm_pkg::LOCK_IDX_W-1:0]    req_lock_r;
  logic [clm_pkg::CLIENT_IDX_W-1:0]  req_client_r;
  logic [STATE_W-1:0]                st_rd_r;
  logic [CLIENT_W-1:0]               hold_rd_r;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [1:0]                        out_status_r;
  logic [1:0]                        out_kind_r;
  logic [clm_pkg::CLIENT_IDX_W-1:0]  out_client_r;
  logic [clm_pkg::LOCK_IDX_W-1:0]    out_lock_r;

  logic                              in_ok;
  logic [LOCK_W-1:0]                 rd_addr;

  logic                              present;
  clm_pkg::mode_t                    mode_eff;
  logic [CLIENT_COUNT-1:0]           wait_eff;
  logic [CLIENT_COUNT-1:0]           cl_bit;
  logic [CLIENT_COUNT-1:0]           wait_less;
  logic [clm_pkg::CLIENT_IDX_W-1:0]  low_waiter;

  clm_pkg::mode_t                    new_mode;
  logic [CLIENT_COUNT-1:0]           new_wait;
  logic [CLIENT_W-1:0]               new_holder;
  logic                              we_state;
  logic                              we_holder;
  clm_pkg::status_t                  res_status;
  clm_pkg::msg_kind_t                res_kind;
  logic [clm_pkg::CLIENT_IDX_W-1:0]  res_dest;

  logic                              wr_en;
  logic [LOCK_W-1:0]                 wr_addr;
  logic [STATE_W-1:0]                wr_data;

  function automatic logic [clm_pkg::CLIENT_IDX_W-1:0] lowest(
    input logic [CLIENT_COUNT-1:0] bits
  );
    logic [clm_pkg::CLIENT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = SEARCH_N - 1; i >= 0; i--) begin
      if (bits[i]) idx = clm_pkg::CLIENT_IDX_W'(i);
    end
    return idx;
  endfunction

  assign in_ok = (32'(in_lock_index) < LOCK_COUNT) && (32'(in_client_index) < CLIENT_COUNT);
  assign rd_addr = in_ok ? LOCK_W'(in_lock_index) : '0;

  assign clr_cnt_nxt = cmd.clear ? clr_cnt_r + LOCK_W'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign sts.clear_last = (clr_cnt_r == LOCK_W'(LOCK_COUNT - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func_r   <= in_func;
      req_ok_r     <= in_ok;
      req_addr_r   <= rd_addr;
      req_lock_r   <= in_lock_index;
      req_client_r <= in_client_index;
      st_rd_r      <= mem_state[rd_addr];
      hold_rd_r    <= mem_holder[rd_addr];
    end
  end

  assign present   = st_rd_r[STATE_W-1];
  assign mode_eff  = present ? clm_pkg::mode_t'(st_rd_r[STATE_W-2:STATE_W-3])
                             : clm_pkg::MODE_FREE;
  assign wait_eff  = present ? st_rd_r[CLIENT_COUNT-1:0] : '0;
  assign cl_bit    = CLIENT_COUNT'(1) << req_client_r;
  assign wait_less = wait_eff & ~cl_bit;
  assign low_waiter = lowest(wait_eff);

  always_comb begin
    new_mode   = mode_eff;
    new_wait   = wait_eff;
    new_holder = hold_rd_r;
    we_state   = 1'b0;
    we_holder  = 1'b0;
    res_status = clm_pkg::STAT_OK;
    res_kind   = clm_pkg::MSG_NONE;
    res_dest   = '0;
    if (!req_ok_r) begin
      res_status = clm_pkg::STAT_NOENT;
    end else if (!req_func_r) begin
      we_state = 1'b1;
      case (mode_eff)
        clm_pkg::MODE_FREE: begin
          new_mode   = clm_pkg::MODE_LOCKED;
          new_holder = CLIENT_W'(req_client_r);
          we_holder  = 1'b1;
        end
        clm_pkg::MODE_LOCKED: begin
          new_mode   = clm_pkg::MODE_WAITED;
          new_wait   = wait_eff | cl_bit;
          res_kind   = clm_pkg::MSG_REVOKE;
          res_dest   = clm_pkg::CLIENT_IDX_W'(hold_rd_r);
          res_status = clm_pkg::STAT_RETRY;
        end
        clm_pkg::MODE_WAITED: begin
          new_wait   = wait_eff | cl_bit;
          res_status = clm_pkg::STAT_RETRY;
        end
        default: begin
          if ((wait_eff & cl_bit) != '0) begin
            new_wait   = wait_less;
            new_holder = CLIENT_W'(req_client_r);
            we_holder  = 1'b1;
            if (wait_less != '0) begin
              new_mode = clm_pkg::MODE_WAITED;
              res_kind = clm_pkg::MSG_REVOKE;
              res_dest = req_client_r;
            end else begin
              new_mode = clm_pkg::MODE_LOCKED;
            end
          end else begin
            new_wait   = wait_eff | cl_bit;
            res_status = clm_pkg::STAT_RETRY;
          end
        end
      endcase
    end else if (!present) begin
      res_status = clm_pkg::STAT_NOENT;
    end else begin
      case (mode_eff)
        clm_pkg::MODE_LOCKED: begin
          new_mode   = clm_pkg::MODE_FREE;
          new_holder = '0;
          we_state   = 1'b1;
          we_holder  = 1'b1;
        end
        clm_pkg::MODE_WAITED: begin
          new_mode   = clm_pkg::MODE_RETRYING;
          new_holder = '0;
          we_state   = 1'b1;
          we_holder  = 1'b1;
          res_kind   = clm_pkg::MSG_RETRY;
          res_dest   = low_waiter;
        end
        default: begin
          res_status = clm_pkg::STAT_BADREL;
        end
      endcase
    end
  end

  assign wr_en   = cmd.clear || (cmd.commit && we_state);
  assign wr_addr = cmd.clear ? clr_cnt_r : req_addr_r;
  assign wr_data = cmd.clear ? '0 : {1'b1, new_mode, new_wait};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_state[wr_addr] <= wr_data;
    end
    if (cmd.commit && we_holder) begin
      mem_holder[req_addr_r] <= new_holder;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_kind_r   <= res_kind;
      out_client_r <= (res_kind != clm_pkg::MSG_NONE) ? res_dest : '0;
      out_lock_r   <= (res_kind != clm_pkg::MSG_NONE) ? req_lock_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_message_kind   = out_kind_r;
  assign out_message_client = out_client_r;
  assign out_message_lock   = out_lock_r;

endmodule

// ===== rtl/caching_lock_manager.sv =====
// channel | handshake           | payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_stall | in_func, in_lock_index, in_client_index
// out     | out_valid/out_stall | out_status, out_message_kind,
//         |                     | out_message_client, out_message_lock
//
// Each request first reads its lock entry through the registered read port, then
// modifies it, writes it back and loads the output register.
// After reset a clearing pass sweeps every entry of the lock state table; in_stall
// stays high meanwhile.
// A stalled result holds the next request in its modify cycle until the transfer.
module caching_lock_manager #(
  parameter int LOCK_COUNT   = 256,
  parameter int CLIENT_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [clm_pkg::LOCK_IDX_W-1:0]   in_lock_index,
  input  logic [clm_pkg::CLIENT_IDX_W-1:0] in_client_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_message_kind,
  output logic [clm_pkg::CLIENT_IDX_W-1:0] out_message_client,
  output logic [clm_pkg::LOCK_IDX_W-1:0]   out_message_lock
);

  clm_pkg::cmd_t cmd;
  clm_pkg::sts_t sts;

  clm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clm_dp #(
    .LOCK_COUNT   (LOCK_COUNT),
    .CLIENT_COUNT (CLIENT_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_lock_index      (in_lock_index),
    .in_client_index    (in_client_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_message_kind   (out_message_kind),
    .out_message_client (out_message_client),
    .out_message_lock   (out_message_lock)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result loaded while output register holds a stalled result");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> in_stall)
    else $error("request accepted during clearing pass");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule
